/* sv/tbce_pkg.sv */
// ----------------------------------------------------------------------------
// Text buffer caret editor package
// Shared types, key codes and outcome codes for the editor core.
// ----------------------------------------------------------------------------
package tbce_pkg;

  localparam int STORE_BYTES = 512;
  localparam int OUT_W       = 9;

  localparam logic [8:0] KEY_UP    = 9'h101;
  localparam logic [8:0] KEY_DOWN  = 9'h102;
  localparam logic [8:0] KEY_LEFT  = 9'h103;
  localparam logic [8:0] KEY_RIGHT = 9'h104;
  localparam logic [8:0] KEY_BS    = 9'd8;
  localparam logic [8:0] KEY_DEL   = 9'd127;
  localparam logic [8:0] KEY_LF    = 9'd10;
  localparam logic [8:0] KEY_CR    = 9'd13;
  localparam logic [8:0] PRINT_LO  = 9'd32;
  localparam logic [8:0] PRINT_HI  = 9'd126;
  localparam logic [7:0] NEWLINE   = 8'd10;

  typedef enum logic [2:0] {
    OUT_MODIFIED = 3'd0,
    OUT_MOVED    = 3'd1,
    OUT_REJECTED = 3'd2,
    OUT_IGNORED  = 3'd3,
    OUT_READ     = 3'd4
  } outcome_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_ROTATE,
    CELL_INSERT,
    CELL_DELETE
  } cell_op_t;

  typedef struct packed {
    cell_op_t   op;
    logic [7:0] data;
  } cell_ctrl_t;

  typedef struct packed {
    logic last;
    logic nl1_v;
    logic nl2_v;
    logic le_v;
    logic ne_v;
  } scan_flags_t;

  typedef struct packed {
    logic       command;
    logic [8:0] key_code;
    logic [8:0] read_address;
  } request_t;

  typedef struct packed {
    logic [8:0] caret_position;
    logic [8:0] text_length;
    logic [8:0] caret_column;
    outcome_t   outcome;
    logic [7:0] read_byte;
  } result_t;

endpackage

/* sv/tbce_cell.sv */
// ----------------------------------------------------------------------------
// Text buffer cell
// One byte of the text store; rotates, opens a gap or closes a gap with
// its neighbors.
// ----------------------------------------------------------------------------
module tbce_cell #(
  parameter int STORE_BYTES = tbce_pkg::STORE_BYTES,
  parameter int INDEX = 0,
  localparam int AW = $clog2(STORE_BYTES)
) (
  input  logic                clk,
  input  logic                rst,
  input  tbce_pkg::cell_ctrl_t ctrl,
  input  logic [AW-1:0]       pos,
  input  logic [7:0]          prev_byte,
  input  logic [7:0]          next_byte,
  output logic [7:0]          data
);
  import tbce_pkg::*;

  localparam logic [AW-1:0] SELF = AW'(INDEX);

  always_ff @(posedge clk) begin
    if (rst) begin
      data <= 8'd0;
    end else begin
      case (ctrl.op)
        CELL_ROTATE: data <= next_byte;
        CELL_INSERT: begin
          if (SELF == pos) begin
            data <= ctrl.data;
          end else if (SELF > pos) begin
            data <= prev_byte;
          end
        end
        CELL_DELETE: begin
          if (SELF >= pos) begin
            data <= next_byte;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

/* sv/tbce_scan.sv */
// ----------------------------------------------------------------------------
// Text buffer line scanner
// Watches the head cell during one turn of the ring and records the
// newline positions around the caret and the byte at the read address.
// ----------------------------------------------------------------------------
module tbce_scan #(
  parameter int STORE_BYTES = tbce_pkg::STORE_BYTES,
  localparam int AW = $clog2(STORE_BYTES)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  clear,
  input  logic                  sample,
  input  logic [7:0]            head,
  input  logic [AW-1:0]         caret,
  input  logic [AW-1:0]         len,
  input  logic [8:0]            read_address,
  output tbce_pkg::scan_flags_t flags,
  output logic [AW-1:0]         nl1,
  output logic [AW-1:0]         nl2,
  output logic [AW-1:0]         le,
  output logic [AW-1:0]         ne,
  output logic [7:0]            rbyte
);
  import tbce_pkg::*;

  localparam int CMPW = (AW > 9) ? AW : 9;
  localparam logic [AW-1:0] LAST = AW'(STORE_BYTES - 1);

  logic [AW-1:0] k;
  logic          is_nl;
  logic          nl1_v;
  logic          nl2_v;
  logic          le_v;
  logic          ne_v;

  assign is_nl = (head == NEWLINE) && (k < len);

  always_comb begin
    flags.last  = (k == LAST);
    flags.nl1_v = nl1_v;
    flags.nl2_v = nl2_v;
    flags.le_v  = le_v;
    flags.ne_v  = ne_v;
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      k     <= '0;
      nl1_v <= 1'b0;
      nl2_v <= 1'b0;
      le_v  <= 1'b0;
      ne_v  <= 1'b0;
      rbyte <= 8'd0;
    end else if (sample) begin
      if (CMPW'(k) == CMPW'(read_address)) begin
        rbyte <= head;
      end
      if (is_nl) begin
        if (k < caret) begin
          nl2   <= nl1;
          nl2_v <= nl1_v;
          nl1   <= k;
          nl1_v <= 1'b1;
        end else if (!le_v) begin
          le   <= k;
          le_v <= 1'b1;
        end else if (!ne_v) begin
          ne   <= k;
          ne_v <= 1'b1;
        end
      end
      k <= (k == LAST) ? '0 : k + AW'(1);
    end
  end

endmodule

/* sv/text_buffer_caret_editor_core.sv */
// ----------------------------------------------------------------------------
// Text buffer caret editor core
// Byte text store with an insertion caret; applies one keystroke or reads
// one stored byte per request.
// ----------------------------------------------------------------------------
// The store is a ring of STORE_BYTES byte cells. Every request turns the ring
// once, one cell per cycle, while the scanner records the line limits around
// the caret; the CALC and APPLY states then work out the new caret and shift
// the tail in one step. A request is taken when start is high and busy is low;
// its result appears with done, which is high for one cycle only, since the
// receiver cannot hold it off; the result itself stays until the next request
// is applied. The next request can be taken in the same cycle as done, and no
// request is taken while busy is high. The store is cleared by a synchronous
// reset.
module text_buffer_caret_editor_core #(
  parameter int STORE_BYTES = tbce_pkg::STORE_BYTES
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  tbce_pkg::request_t request,
  output logic               busy,
  output logic               done,
  output tbce_pkg::result_t  result
);
  import tbce_pkg::*;

  localparam int AW = $clog2(STORE_BYTES);
  localparam logic [AW-1:0] ONE  = AW'(1);
  localparam logic [AW:0]   SIZE = (AW+1)'(STORE_BYTES);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CALC,
    ST_APPLY
  } state_t;

  state_t        state;
  logic [AW-1:0] caret;
  logic [AW-1:0] len;
  logic          cmd;
  logic [8:0]    key;
  logic [8:0]    addr;

  logic [AW-1:0] col_q;
  logic [AW-1:0] ps_q;
  logic [AW-1:0] plen_q;
  logic [AW-1:0] le_q;
  logic [AW-1:0] ns_q;
  logic [AW-1:0] nlen_q;
  logic          del_nl_q;
  logic          full_q;

  scan_flags_t   flags;
  logic [AW-1:0] nl1;
  logic [AW-1:0] nl2;
  logic [AW-1:0] le;
  logic [AW-1:0] ne;
  logic [7:0]    rbyte;

  logic [7:0]    cell_q [STORE_BYTES];
  logic [7:0]    prev_w [STORE_BYTES];
  logic [7:0]    next_w [STORE_BYTES];
  cell_ctrl_t    cell_ctrl;
  logic [AW-1:0] cell_pos;

  logic [AW-1:0] caret_next;
  logic [AW-1:0] len_next;
  logic [AW-1:0] col_next;
  outcome_t      outcome_next;
  cell_op_t      edit_op;
  logic [AW-1:0] up_col;
  logic [AW-1:0] dn_col;
  logic          key_nl;

  assign busy = (state != ST_IDLE);

  tbce_scan #(.STORE_BYTES(STORE_BYTES)) u_scan (
    .clk          (clk),
    .rst          (rst),
    .clear        (start && !busy),
    .sample       (state == ST_SCAN),
    .head         (cell_q[0]),
    .caret        (caret),
    .len          (len),
    .read_address (addr),
    .flags        (flags),
    .nl1          (nl1),
    .nl2          (nl2),
    .le           (le),
    .ne           (ne),
    .rbyte        (rbyte)
  );

  for (genvar i = 0; i < STORE_BYTES; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign prev_w[i] = 8'd0;
    end else begin : g_prev
      assign prev_w[i] = cell_q[i-1];
    end
    if (i == STORE_BYTES - 1) begin : g_last
      assign next_w[i] = (cell_ctrl.op == CELL_ROTATE) ? cell_q[0] : 8'd0;
    end else begin : g_next
      assign next_w[i] = cell_q[i+1];
    end
    tbce_cell #(.STORE_BYTES(STORE_BYTES), .INDEX(i)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (cell_ctrl),
      .pos       (cell_pos),
      .prev_byte (prev_w[i]),
      .next_byte (next_w[i]),
      .data      (cell_q[i])
    );
  end

  assign up_col = (col_q < plen_q) ? col_q : plen_q;
  assign dn_col = (col_q < nlen_q) ? col_q : nlen_q;
  assign key_nl = (key == KEY_LF) || (key == KEY_CR);

  always_comb begin
    caret_next   = caret;
    len_next     = len;
    col_next     = col_q;
    outcome_next = OUT_MOVED;
    edit_op      = CELL_HOLD;
    cell_pos     = caret;
    if (cmd) begin
      outcome_next = OUT_READ;
    end else begin
      case (key) inside
        KEY_LEFT: begin
          if (col_q != '0) begin
            caret_next = caret - ONE;
            col_next   = col_q - ONE;
          end
        end
        KEY_RIGHT: begin
          if (caret < le_q) begin
            caret_next = caret + ONE;
            col_next   = col_q + ONE;
          end
        end
        KEY_UP: begin
          if (flags.nl1_v) begin
            caret_next = ps_q + up_col;
            col_next   = up_col;
          end
        end
        KEY_DOWN: begin
          if (flags.le_v) begin
            caret_next = ns_q + dn_col;
            col_next   = dn_col;
          end
        end
        KEY_BS, KEY_DEL: begin
          if (caret == '0) begin
            outcome_next = OUT_REJECTED;
          end else begin
            outcome_next = OUT_MODIFIED;
            caret_next   = caret - ONE;
            len_next     = len - ONE;
            col_next     = del_nl_q ? plen_q : col_q - ONE;
            edit_op      = CELL_DELETE;
            cell_pos     = caret - ONE;
          end
        end
        KEY_LF, KEY_CR, [PRINT_LO:PRINT_HI]: begin
          if (full_q) begin
            outcome_next = OUT_REJECTED;
          end else begin
            outcome_next = OUT_MODIFIED;
            caret_next   = caret + ONE;
            len_next     = len + ONE;
            col_next     = key_nl ? '0 : col_q + ONE;
            edit_op      = CELL_INSERT;
          end
        end
        default: outcome_next = OUT_IGNORED;
      endcase
    end
  end

  always_comb begin
    cell_ctrl.data = key_nl ? NEWLINE : key[7:0];
    case (state)
      ST_SCAN:  cell_ctrl.op = CELL_ROTATE;
      ST_APPLY: cell_ctrl.op = edit_op;
      default:  cell_ctrl.op = CELL_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      caret <= '0;
      len   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            cmd   <= request.command;
            key   <= request.key_code;
            addr  <= request.read_address;
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (flags.last) begin
            state <= ST_CALC;
          end
        end
        ST_CALC: begin
          col_q    <= flags.nl1_v ? caret - nl1 - ONE : caret;
          ps_q     <= flags.nl2_v ? nl2 + ONE : '0;
          plen_q   <= flags.nl2_v ? nl1 - nl2 - ONE : nl1;
          le_q     <= flags.le_v ? le : len;
          ns_q     <= le + ONE;
          nlen_q   <= (flags.ne_v ? ne : len) - le - ONE;
          del_nl_q <= flags.nl1_v && (nl1 == caret - ONE);
          full_q   <= ({1'b0, len} + (AW+1)'(1)) >= SIZE;
          state    <= ST_APPLY;
        end
        ST_APPLY: begin
          caret                 <= caret_next;
          len                   <= len_next;
          result.caret_position <= OUT_W'(caret_next);
          result.text_length    <= OUT_W'(len_next);
          result.caret_column   <= OUT_W'(col_next);
          result.outcome        <= outcome_next;
          result.read_byte      <= cmd ? rbyte : 8'd0;
          done                  <= 1'b1;
          state                 <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Text buffer caret editor core testbench
// Sends keystroke and byte read requests to the core. A tracker keeps its own
// text store, length and caret, predicts every result and checks each strobed
// result against it. Covers the empty text, deletion at the start, arrows at
// line boundaries and ignored key codes.
// ----------------------------------------------------------------------------
module testbench;
  import tbce_pkg::*;

  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam int DRAIN_CYCLES = STORE_BYTES + 8;
  localparam int REPORT_MAX   = 10;

  class caret_edit_tracker;
    logic [7:0] text_bytes [STORE_BYTES];
    int         text_len;
    int         caret_at;
    int         mismatches;
    result_t    awaited_results [$];

    function new();
      foreach (text_bytes[i]) text_bytes[i] = '0;
      text_len   = 0;
      caret_at   = 0;
      mismatches = 0;
    endfunction

    function int pending();
      return awaited_results.size();
    endfunction

    function int row_head(int pos);
      int first;
      first = 0;
      if (pos > text_len) pos = text_len;
      for (int i = 0; i < pos; i++)
        if (text_bytes[i] == NEWLINE) first = i + 1;
      return first;
    endfunction

    function int row_tail(int pos);
      if (pos > text_len) pos = text_len;
      for (int i = pos; i < text_len; i++)
        if (text_bytes[i] == NEWLINE) return i;
      return text_len;
    endfunction

    function outcome_t insert_byte(logic [7:0] value);
      if (text_len + 1 >= STORE_BYTES) return OUT_REJECTED;
      for (int i = text_len; i > caret_at; i--) text_bytes[i] = text_bytes[i - 1];
      text_bytes[caret_at] = value;
      text_len++;
      caret_at++;
      text_bytes[text_len] = '0;
      return OUT_MODIFIED;
    endfunction

    function outcome_t erase_before_caret();
      if (caret_at == 0) return OUT_REJECTED;
      caret_at--;
      for (int i = caret_at; i + 1 < text_len; i++) text_bytes[i] = text_bytes[i + 1];
      text_len--;
      text_bytes[text_len] = '0;
      return OUT_MODIFIED;
    endfunction

    function void caret_up();
      int ls, col, pe, ps, plen;
      ls = row_head(caret_at);
      if (ls == 0) return;
      col  = caret_at - ls;
      pe   = ls - 1;
      ps   = row_head(pe);
      plen = pe - ps;
      caret_at = ps + ((col < plen) ? col : plen);
    endfunction

    function void caret_down();
      int le, col, ns, ne, nlen;
      le = row_tail(caret_at);
      if (le >= text_len) return;
      col  = caret_at - row_head(caret_at);
      ns   = le + 1;
      ne   = row_tail(ns);
      nlen = ne - ns;
      caret_at = ns + ((col < nlen) ? col : nlen);
    endfunction

    function void note_request(request_t req);
      result_t  res;
      outcome_t oc;
      res = '0;
      if (req.command) begin
        if (int'(req.read_address) < STORE_BYTES) res.read_byte = text_bytes[req.read_address];
        oc = OUT_READ;
      end else if (req.key_code == KEY_LEFT) begin
        if (caret_at > row_head(caret_at)) caret_at--;
        oc = OUT_MOVED;
      end else if (req.key_code == KEY_RIGHT) begin
        if (caret_at < row_tail(caret_at)) caret_at++;
        oc = OUT_MOVED;
      end else if (req.key_code == KEY_UP) begin
        caret_up();
        oc = OUT_MOVED;
      end else if (req.key_code == KEY_DOWN) begin
        caret_down();
        oc = OUT_MOVED;
      end else if (req.key_code == KEY_BS || req.key_code == KEY_DEL) begin
        oc = erase_before_caret();
      end else if (req.key_code == KEY_LF || req.key_code == KEY_CR) begin
        oc = insert_byte(NEWLINE);
      end else if (req.key_code >= PRINT_LO && req.key_code <= PRINT_HI) begin
        oc = insert_byte(req.key_code[7:0]);
      end else begin
        oc = OUT_IGNORED;
      end
      res.caret_position = 9'(caret_at);
      res.text_length    = 9'(text_len);
      res.caret_column   = 9'(caret_at - row_head(caret_at));
      res.outcome        = oc;
      awaited_results.push_back(res);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (awaited_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected result: caret %0d len %0d col %0d outcome %0d byte %0h",
                   got.caret_position, got.text_length, got.caret_column, got.outcome,
                   got.read_byte);
        return;
      end
      want = awaited_results.pop_front();
      if (got.caret_position != want.caret_position || got.text_length != want.text_length ||
          got.caret_column != want.caret_column || got.outcome != want.outcome ||
          got.read_byte != want.read_byte) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("mismatch: expected caret %0d len %0d col %0d outcome %0d byte %0h",
                   want.caret_position, want.text_length, want.caret_column, want.outcome,
                   want.read_byte);
          $display("          actual   caret %0d len %0d col %0d outcome %0d byte %0h",
                   got.caret_position, got.text_length, got.caret_column, got.outcome,
                   got.read_byte);
        end
      end
    endfunction
  endclass

  logic              clk     = 1'b0;
  logic              rst     = 1'b1;
  logic              start   = 1'b0;
  request_t          request = '0;
  logic              busy;
  logic              done;
  result_t           result;
  caret_edit_tracker tracker = new();
  int unsigned       cycle_count = 0;
  bit                idle_allowed = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  text_buffer_caret_editor_core u_top (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .request (request),
    .busy    (busy),
    .done    (done),
    .result  (result)
  );

  always @(posedge clk) begin
    if (!rst && done) tracker.check_result(result);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic request_t keystroke(logic [8:0] key);
    request_t req;
    req.command      = 1'b0;
    req.key_code     = key;
    req.read_address = 9'($urandom_range(0, 511));
    return req;
  endfunction

  function automatic request_t byte_read(int addr);
    request_t req;
    req.command      = 1'b1;
    req.key_code     = 9'($urandom_range(0, 511));
    req.read_address = 9'(addr);
    return req;
  endfunction

  function automatic request_t random_edit(int insert_w, int erase_w, int arrow_w,
                                           int read_w, int noise_w);
    int roll, top_addr;
    roll = $urandom_range(0, insert_w + erase_w + arrow_w + read_w + noise_w - 1);
    if (roll < insert_w) begin
      if ($urandom_range(0, 7) == 0) return keystroke($urandom_range(0, 1) ? KEY_LF : KEY_CR);
      return keystroke(9'($urandom_range(PRINT_LO, PRINT_HI)));
    end
    roll -= insert_w;
    if (roll < erase_w) return keystroke($urandom_range(0, 1) ? KEY_BS : KEY_DEL);
    roll -= erase_w;
    if (roll < arrow_w) return keystroke(9'($urandom_range(KEY_UP, KEY_RIGHT)));
    roll -= arrow_w;
    if (roll < read_w) begin
      top_addr = (tracker.text_len + 2 > 511) ? 511 : tracker.text_len + 2;
      if ($urandom_range(0, 3) == 0) return byte_read($urandom_range(0, 511));
      return byte_read($urandom_range(0, top_addr));
    end
    return keystroke(9'($urandom_range(0, 511)));
  endfunction

  task automatic issue(input request_t req);
    int unsigned gap;
    if (idle_allowed && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      start <= 1'b0;
      do @(posedge clk); while (busy);
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    request <= req;
    do @(posedge clk); while (busy);
    tracker.note_request(req);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    issue(keystroke(KEY_BS));
    issue(keystroke(KEY_DEL));
    issue(keystroke(KEY_LEFT));
    issue(keystroke(KEY_RIGHT));
    issue(keystroke(KEY_UP));
    issue(keystroke(KEY_DOWN));
    issue(byte_read(0));
    issue(byte_read(511));
    issue(keystroke('0));
    issue(keystroke(PRINT_LO - 9'd1));
    issue(keystroke(KEY_DEL + 9'd1));
    issue(keystroke(KEY_UP - 9'd1));
    issue(keystroke(KEY_RIGHT + 9'd1));
    issue(keystroke('1));
    issue(keystroke(PRINT_LO));
    issue(keystroke(PRINT_HI));
    issue(keystroke(KEY_LF));
    issue(keystroke(KEY_CR));
    issue(keystroke(PRINT_LO + 9'd33));
    issue(keystroke(PRINT_HI - 9'd28));
    issue(keystroke(KEY_UP));
    issue(keystroke(KEY_UP));
    issue(keystroke(KEY_RIGHT));
    issue(keystroke(KEY_DOWN));
    issue(byte_read(1));
    wait_drained();

    repeat (180) issue(random_edit(45, 15, 25, 10, 5));
    wait_drained();

    repeat (160) issue(random_edit(15, 50, 20, 10, 5));
    idle_allowed = 1'b0;
    repeat (85) issue(random_edit(40, 20, 25, 10, 5));

    start <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
